FILE: sv/rbt_pkg.sv
// ----------------------------------------------------------------------------
// rbt_pkg
// shared types, codes and widths for the retry backoff tracker
// ----------------------------------------------------------------------------
`default_nettype none

package rbt_pkg;

  localparam int unsigned TickW    = 64;
  localparam int unsigned CountW   = 32;
  localparam int unsigned DelayW   = 32;
  localparam int unsigned ShiftW   = 6;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned InUserW  = 4;
  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 104;
  localparam int unsigned OutUsedW = 1 + 2 + CountW + TickW + 1 + 1;
  localparam int unsigned OutPadW  = OutDataW - OutUsedW;

  // reset values of the configuration registers
  localparam logic [DelayW-1:0] MaxDelayRst = 32'd1000000;
  localparam logic [ShiftW-1:0] MaxShiftRst = 6'd6;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_MAX_DELAY = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_SHIFT = 1'b1;

  typedef enum logic [1:0] {
    CMD_DEFER    = 2'd0,
    CMD_CANCEL   = 2'd1,
    CMD_COMPLETE = 2'd2,
    CMD_QUERY    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_SUCCESS   = 2'd0,
    ST_PROGRESS  = 2'd1,
    ST_RETRY     = 2'd2,
    ST_PERMANENT = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OUT_RETRY     = 2'd0,
    OUT_READY     = 2'd1,
    OUT_PERMANENT = 2'd2
  } outcome_e;

  // one request as held in the input register
  typedef struct packed {
    cmd_e              command;
    status_e           status_kind;
    logic [TickW-1:0]  now;
  } in_item_t;

  // exec stage result, carries the new state needed for the due check
  typedef struct packed {
    logic              accepted;
    outcome_e          outcome;
    logic [CountW-1:0] failure_count;
    logic [TickW-1:0]  deadline;
    logic              is_pending;
    logic [TickW-1:0]  retry_time;
    logic [TickW-1:0]  now;
  } exec_result_t;

  // result packing on the master tdata, accepted in the lowest bit
  typedef struct packed {
    logic [OutPadW-1:0] pad;
    logic               is_due;
    logic               is_pending;
    logic [TickW-1:0]   deadline;
    logic [CountW-1:0]  failure_count;
    outcome_e           outcome;
    logic               accepted;
  } out_item_t;

endpackage

`default_nettype wire

FILE: sv/retry_backoff_tracker.sv
// Pipeline: a request accepted on s_axis passes the input register, exec register
//   and output register before its result shows on m_axis.
// Throughput: one request per cycle while m_axis accepts; the tracker state updates in the exec
//   stage, so each request sees the state left by the one before it.
// Reset: clears the tracker (not pending, count and retry tick zero), empties
//   the pipeline and loads max_delay = 1000000 and max_shift = 6.
// ----------------------------------------------------------------------------
// retry_backoff_tracker
// one pending retry with capped exponential backoff and wrap-safe due check
// ----------------------------------------------------------------------------
`default_nettype none

module retry_backoff_tracker (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // request stream
  input  wire                               s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  wire [rbt_pkg::InDataW-1:0]        s_axis_tdata_i,  // now[63:0]
  input  wire [rbt_pkg::InUserW-1:0]        s_axis_tuser_i,  // command[1:0], status_kind[3:2]
  // result stream
  output logic                              m_axis_tvalid_o,
  input  wire                               m_axis_tready_i,
  // accepted[0], outcome[2:1], failure_count[34:3], deadline[98:35],
  // is_pending[99], is_due[100], zero pad[103:101]
  output logic [rbt_pkg::OutDataW-1:0]      m_axis_tdata_o,
  // configuration writes
  input  wire                               cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire [rbt_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  wire [rbt_pkg::CfgDataW-1:0]       cfg_data_i
);
  import rbt_pkg::*;

  logic              in_valid_q;
  in_item_t          in_q;
  logic              exec_ready;
  logic              exec_valid;
  exec_result_t      exec_res;
  logic              due_ready;
  logic [DelayW-1:0] max_delay_q;
  logic [ShiftW-1:0] max_shift_q;

  // configuration registers, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_delay_q <= MaxDelayRst;
      max_shift_q <= MaxShiftRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MAX_DELAY: max_delay_q <= cfg_data_i;
        CFG_MAX_SHIFT: max_shift_q <= cfg_data_i[ShiftW-1:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  assign s_axis_tready_o = !in_valid_q || exec_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_q.command     <= cmd_e'(s_axis_tuser_i[1:0]);
      in_q.status_kind <= status_e'(s_axis_tuser_i[3:2]);
      in_q.now         <= s_axis_tdata_i;
    end
  end

  // command execution and state
  rbt_exec u_exec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_valid_q),
    .ready_o     (exec_ready),
    .item_i      (in_q),
    .max_delay_i (max_delay_q),
    .max_shift_i (max_shift_q),
    .valid_o     (exec_valid),
    .ready_i     (due_ready),
    .res_o       (exec_res)
  );

  // due check and output register
  rbt_due u_due (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (exec_valid),
    .ready_o         (due_ready),
    .res_i           (exec_res),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // input side stalls only when every stage is full and the sink holds off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (m_axis_tvalid_o && !m_axis_tready_i && exec_valid))
    else $error("input stalled while pipeline has room");

  // a due retry is always pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[100] == 1'b0 || m_axis_tdata_o[99] == 1'b1))
    else $error("due reported without pending retry");

  // an accepted defer leaves the tracker armed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[0]) |-> m_axis_tdata_o[99])
    else $error("accepted defer without pending retry");

  // deadline only reported with a retry outcome
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[2:1] != OUT_RETRY) |-> m_axis_tdata_o[98:35] == '0)
    else $error("deadline reported with ready or permanent outcome");

endmodule

`default_nettype wire

FILE: sv/rbt_exec.sv
// ----------------------------------------------------------------------------
// rbt_exec
// command execution: owns the tracker state and registers the step result
// ----------------------------------------------------------------------------
`default_nettype none

module rbt_exec (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               valid_i,
  output logic                              ready_o,
  input  wire rbt_pkg::in_item_t            item_i,
  input  wire [rbt_pkg::DelayW-1:0]         max_delay_i,
  input  wire [rbt_pkg::ShiftW-1:0]         max_shift_i,
  output logic                              valid_o,
  input  wire                               ready_i,
  output rbt_pkg::exec_result_t             res_o
);
  import rbt_pkg::*;

  logic              valid_q;
  logic              pending_q, pending_d;
  logic [CountW-1:0] fail_q, fail_d;
  logic [TickW-1:0]  rt_q, rt_d;
  exec_result_t      res_q, res_d;
  logic              step;

  logic              retryable;
  logic [CountW-1:0] fail_inc;
  logic [ShiftW-1:0] shift;
  logic [TickW-1:0]  pow;
  logic [TickW-1:0]  delay;
  logic [TickW-1:0]  addend;
  logic [TickW:0]    sum;
  logic [TickW-1:0]  rt_adv;

  assign ready_o = !valid_q || ready_i;
  assign step    = valid_i && ready_o;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  // backoff delay and saturating deadline, shared by progress and failure
  always_comb begin
    retryable = (item_i.status_kind == ST_PROGRESS) || (item_i.status_kind == ST_RETRY);
    fail_inc  = (fail_q == '1) ? fail_q : fail_q + 1'b1;
    shift     = (fail_inc < CountW'(max_shift_i)) ? fail_inc[ShiftW-1:0] : max_shift_i;
    pow       = TickW'(1) << shift;
    delay     = (pow > TickW'(max_delay_i)) ? TickW'(max_delay_i) : pow;
    addend    = (item_i.status_kind == ST_PROGRESS) ? TickW'(1) : delay;
    sum       = {1'b0, item_i.now} + {1'b0, addend};
    rt_adv    = sum[TickW] ? '1 : sum[TickW-1:0];
  end

  // command decode and next state
  always_comb begin
    pending_d = pending_q;
    fail_d    = fail_q;
    rt_d      = rt_q;
    res_d     = '0;
    res_d.outcome = OUT_RETRY;
    case (item_i.command)
      CMD_DEFER: begin
        if (retryable) begin
          pending_d      = 1'b1;
          fail_d         = '0;
          rt_d           = item_i.now;
          res_d.accepted = 1'b1;
        end
      end
      CMD_CANCEL: begin
        pending_d = 1'b0;
        fail_d    = '0;
        rt_d      = '0;
      end
      CMD_COMPLETE: begin
        res_d.failure_count = fail_q;
        if (pending_q) begin
          case (item_i.status_kind)
            ST_SUCCESS: begin
              res_d.outcome = OUT_READY;
              pending_d     = 1'b0;
              fail_d        = '0;
              rt_d          = '0;
            end
            ST_PERMANENT: begin
              res_d.outcome = OUT_PERMANENT;
              pending_d     = 1'b0;
            end
            ST_PROGRESS: begin
              rt_d = rt_adv;
            end
            default: begin
              fail_d              = fail_inc;
              res_d.failure_count = fail_inc;
              rt_d                = rt_adv;
            end
          endcase
        end
        if (res_d.outcome == OUT_RETRY) begin
          res_d.deadline = rt_d;
        end
      end
      default: begin
        // query leaves the state alone
      end
    endcase
    res_d.is_pending = pending_d;
    res_d.retry_time = rt_d;
    res_d.now        = item_i.now;
  end

  // tracker state and stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      pending_q <= 1'b0;
      fail_q    <= '0;
      rt_q      <= '0;
    end else begin
      if (ready_o) begin
        valid_q <= valid_i;
      end
      if (step) begin
        pending_q <= pending_d;
        fail_q    <= fail_d;
        rt_q      <= rt_d;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/rbt_due.sv
// ----------------------------------------------------------------------------
// rbt_due
// output stage: wrap-safe due check and the result register on the bus
// ----------------------------------------------------------------------------
`default_nettype none

module rbt_due (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               valid_i,
  output logic                              ready_o,
  input  wire rbt_pkg::exec_result_t        res_i,
  output logic                              m_axis_tvalid_o,
  input  wire                               m_axis_tready_i,
  output logic [rbt_pkg::OutDataW-1:0]      m_axis_tdata_o
);
  import rbt_pkg::*;

  logic             valid_q;
  out_item_t        out_q, out_d;
  logic [TickW-1:0] diff;

  assign ready_o         = !valid_q || m_axis_tready_i;
  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = out_q;

  // due when pending and now minus retry tick is not negative
  always_comb begin
    diff                = res_i.now - res_i.retry_time;
    out_d               = '0;
    out_d.accepted      = res_i.accepted;
    out_d.outcome       = res_i.outcome;
    out_d.failure_count = res_i.failure_count;
    out_d.deadline      = res_i.deadline;
    out_d.is_pending    = res_i.is_pending;
    out_d.is_due        = res_i.is_pending && !diff[TickW-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      out_q <= out_d;
    end
  end

endmodule

`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// retry backoff tracker testbench
// drives command requests with random tick values and idle gaps on both
// streams, predicts every result from a local copy of the tracker state
// and checks each result field by field, in order, over several register
// settings
// ----------------------------------------------------------------------------

module testbench;
  import rbt_pkg::*;

  localparam int unsigned CycleLimit = 200000;

  // tracker prediction and the queue of results still to come
  class backoff_checker;
    logic              armed;
    logic [CountW-1:0] fails;
    logic [TickW-1:0]  retry_at;
    logic [DelayW-1:0] delay_cap;
    logic [ShiftW-1:0] shift_cap;
    out_item_t         awaited[$];
    int                errors;
    int                checked;
    int                due_seen;

    function new();
      armed     = 1'b0;
      fails     = '0;
      retry_at  = '0;
      delay_cap = MaxDelayRst;
      shift_cap = MaxShiftRst;
      errors    = 0;
      checked   = 0;
      due_seen  = 0;
    endfunction

    function void set_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
      if (idx == CFG_MAX_DELAY) begin
        delay_cap = value[DelayW-1:0];
      end else begin
        shift_cap = value[ShiftW-1:0];
      end
    endfunction

    // advance the tracker by one accepted request and queue its result
    function void note_request(cmd_e cmd, status_e kind, logic [TickW-1:0] now);
      out_item_t         res;
      logic [TickW-1:0]  delay;
      logic [ShiftW-1:0] shift;
      logic [TickW-1:0]  diff;
      res = '0;
      res.outcome = OUT_RETRY;
      case (cmd)
        CMD_DEFER: begin
          if (kind == ST_PROGRESS || kind == ST_RETRY) begin
            armed    = 1'b1;
            fails    = '0;
            retry_at = now;
            res.accepted = 1'b1;
          end
        end
        CMD_CANCEL: begin
          armed    = 1'b0;
          fails    = '0;
          retry_at = '0;
        end
        CMD_COMPLETE: begin
          res.failure_count = fails;
          if (armed) begin
            case (kind)
              ST_SUCCESS: begin
                res.outcome = OUT_READY;
                armed    = 1'b0;
                fails    = '0;
                retry_at = '0;
              end
              ST_PERMANENT: begin
                res.outcome = OUT_PERMANENT;
                armed = 1'b0;
              end
              ST_PROGRESS: begin
                retry_at = (now == '1) ? now : now + 64'd1;
              end
              default: begin
                // retryable failure: saturating count, capped doubling delay
                if (fails != '1) fails = fails + 32'd1;
                res.failure_count = fails;
                shift = (fails < {26'd0, shift_cap}) ? fails[ShiftW-1:0] : shift_cap;
                delay = 64'd1 << shift;
                if (delay > {32'd0, delay_cap}) delay = {32'd0, delay_cap};
                retry_at = (now > ~64'd0 - delay) ? '1 : now + delay;
              end
            endcase
          end
          if (res.outcome == OUT_RETRY) res.deadline = retry_at;
        end
        default: ;
      endcase
      // wrap-safe due check on the state after the step
      diff = now - retry_at;
      res.is_pending = armed;
      res.is_due     = armed && !diff[TickW-1];
      if (res.is_due) due_seen++;
      awaited.push_back(res);
    endfunction

    function void compare_field(string field, logic [TickW-1:0] want, logic [TickW-1:0] seen);
      if (want !== seen) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, seen);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: result with nothing awaited, got %0h", $time, got);
      end else begin
        want = awaited.pop_front();
        checked++;
        compare_field("accepted", want.accepted, got.accepted);
        compare_field("outcome", want.outcome, got.outcome);
        compare_field("failure_count", want.failure_count, got.failure_count);
        compare_field("deadline", want.deadline, got.deadline);
        compare_field("is_pending", want.is_pending, got.is_pending);
        compare_field("is_due", want.is_due, got.is_due);
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata = '0;
  logic [InUserW-1:0]  s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  backoff_checker board;
  int          cycles = 0;
  int          hold_off_cycles = 0;
  bit          tx_quiet = 1'b0;
  bit          rx_quiet = 1'b0;
  int          cmd_count[4] = '{0, 0, 0, 0};
  int          settings_used = 1;

  retry_backoff_tracker dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // result checking
  always @(posedge clk) begin
    if (rst_n && m_tvalid && m_tready) board.check_result(out_item_t'(m_tdata));
  end

  // result side ready: random stalls, one long hold-off on request
  initial begin
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_off_cycles != 0) begin
        m_tready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end else if (!rx_quiet && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  // offer one request and wait for it to be taken
  task automatic send_request(cmd_e cmd, status_e kind, logic [TickW-1:0] now);
    s_tvalid <= 1'b1;
    s_tdata  <= now;
    s_tuser  <= {kind, cmd};
    do @(posedge clk); while (!s_tready);
    board.note_request(cmd, kind, now);
    cmd_count[cmd]++;
    if (!tx_quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // stop offering until every result is back
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (board.awaited.size() != 0);
  endtask

  task automatic write_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    board.set_register(idx, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // new register setting once the tracker is idle
  task automatic reconfigure(logic [DelayW-1:0] max_delay, logic [ShiftW-1:0] max_shift);
    drain();
    repeat (4) @(posedge clk);
    write_register(CFG_MAX_DELAY, max_delay);
    write_register(CFG_MAX_SHIFT, {26'd0, max_shift});
    settings_used++;
  endtask

  function automatic logic [TickW-1:0] rand_tick();
    case ($urandom_range(0, 3))
      0: return {$urandom, $urandom};
      1: return ~64'd0 - $urandom_range(0, 50);
      2: return 64'd0 + $urandom_range(0, 50);
      default: return 64'h7FFF_FFFF_FFFF_FFE7 + $urandom_range(0, 50);
    endcase
  endfunction

  // mostly defer, completes and queries on a moving tick, some noise
  task automatic random_traffic(int n_items);
    int               done;
    int               len;
    int               pick;
    logic [TickW-1:0] tick;
    done = 0;
    while (done < n_items) begin
      if ($urandom_range(0, 4) == 0) begin
        send_request(cmd_e'($urandom_range(0, 3)), status_e'($urandom_range(0, 3)),
                     rand_tick());
        done++;
      end else begin
        tick = rand_tick();
        send_request(CMD_DEFER, $urandom_range(0, 1) ? ST_RETRY : ST_PROGRESS, tick);
        done++;
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 45) : $urandom_range(1, 10);
        repeat (len) begin
          tick = tick + (($urandom_range(0, 5) == 0) ? {$urandom, $urandom}
                                                     : 64'd0 + $urandom_range(0, 2000));
          pick = $urandom_range(0, 9);
          if (pick < 6) begin
            send_request(CMD_COMPLETE, ST_RETRY, tick);
          end else if (pick < 7) begin
            send_request(CMD_COMPLETE, ST_PROGRESS, tick);
          end else if (pick < 9) begin
            // query right around the predicted retry tick
            send_request(CMD_QUERY, status_e'($urandom_range(0, 3)),
                         board.retry_at + $urandom_range(0, 2) - 64'd1);
          end else begin
            send_request(CMD_QUERY, status_e'($urandom_range(0, 3)), tick);
          end
          done++;
        end
        // close the sequence, or leave it armed
        case ($urandom_range(0, 3))
          0: send_request(CMD_COMPLETE, ST_SUCCESS, tick);
          1: send_request(CMD_COMPLETE, ST_PERMANENT, tick);
          2: send_request(CMD_CANCEL, status_e'($urandom_range(0, 3)), tick);
          default: ;
        endcase
        done++;
      end
    end
  endtask

  initial begin
    board = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle tracker, defer filtering, backoff, saturation, wrap
    send_request(CMD_QUERY, ST_SUCCESS, 64'd0);
    send_request(CMD_COMPLETE, ST_RETRY, 64'd5);
    send_request(CMD_DEFER, ST_SUCCESS, 64'd10);
    send_request(CMD_DEFER, ST_PERMANENT, 64'd10);
    send_request(CMD_DEFER, ST_PROGRESS, 64'd100);
    send_request(CMD_QUERY, ST_PROGRESS, 64'd99);
    send_request(CMD_QUERY, ST_RETRY, 64'd100);
    send_request(CMD_COMPLETE, ST_RETRY, 64'd100);
    send_request(CMD_COMPLETE, ST_RETRY, 64'd200);
    send_request(CMD_COMPLETE, ST_PROGRESS, 64'd300);
    send_request(CMD_COMPLETE, ST_PERMANENT, 64'd400);
    send_request(CMD_COMPLETE, ST_SUCCESS, 64'd500);
    send_request(CMD_CANCEL, ST_PERMANENT, 64'd0);
    send_request(CMD_DEFER, ST_RETRY, ~64'd0 - 64'd3);
    send_request(CMD_COMPLETE, ST_RETRY, ~64'd0);
    send_request(CMD_COMPLETE, ST_PROGRESS, ~64'd0);
    send_request(CMD_QUERY, ST_SUCCESS, 64'd3);
    send_request(CMD_QUERY, ST_SUCCESS, 64'h7FFF_FFFF_FFFF_FFFE);
    send_request(CMD_QUERY, ST_SUCCESS, 64'h7FFF_FFFF_FFFF_FFFF);
    send_request(CMD_COMPLETE, ST_SUCCESS, 64'd0);
    send_request(CMD_DEFER, ST_RETRY, 64'h8000_0000_0000_0000);
    send_request(CMD_QUERY, ST_RETRY, 64'd0);
    send_request(CMD_CANCEL, ST_SUCCESS, ~64'd0);
    send_request(CMD_QUERY, ST_PERMANENT, ~64'd0);

    // reset setting, with one long hold-off on the result side
    random_traffic(80);
    tx_quiet = 1'b1;
    hold_off_cycles = 80;
    random_traffic(20);
    tx_quiet = 1'b0;

    // widest delay and shift
    reconfigure(32'hFFFF_FFFF, 6'd63);
    random_traffic(90);

    // smallest delay and shift, with a full pause midway
    reconfigure(32'd1, 6'd0);
    random_traffic(35);
    drain();
    random_traffic(35);

    // random setting
    reconfigure(($urandom == 0) ? 32'd1 : $urandom, 6'($urandom_range(0, 63)));
    random_traffic(90);

    // last part with no idling on either side
    reconfigure(32'd5000, 6'd12);
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    random_traffic(100);

    drain();
    repeat (8) @(posedge clk);
    if (board.awaited.size() != 0) begin
      board.errors++;
      $display("%0t: %0d results never arrived", $time, board.awaited.size());
    end
    $display("requests: %0d defer, %0d cancel, %0d complete, %0d query; %0d results checked",
             cmd_count[CMD_DEFER], cmd_count[CMD_CANCEL], cmd_count[CMD_COMPLETE],
             cmd_count[CMD_QUERY], board.checked);
    $display("%0d register settings, %0d due reports, %0d mismatches",
             settings_used, board.due_seen, board.errors);
    if (board.errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
